@@ rtl/core/unordered_key_table_core_macros.svh @@
// assertion helpers shared by the table core
`ifndef UNORDERED_KEY_TABLE_CORE_MACROS_SVH
`define UNORDERED_KEY_TABLE_CORE_MACROS_SVH

// same-cycle implication under reset
`define UKT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("table core check failed");

// next-cycle implication under reset
`define UKT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("table core check failed");

`endif

@@ rtl/core/ukt_pkg.sv @@
package ukt_pkg;

	// table geometry
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// fixed payload widths
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int HIDX_W  = 6;
	localparam int ECNT_W  = 7;

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_SEARCH = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// search token walking the cell row
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic             found;
		logic [IDX_W-1:0] slot;
		logic [VAL_W-1:0] value;
		logic [KEY_W-1:0] last_key;
		logic [VAL_W-1:0] last_value;
	} ukt_tok_t;

	// slot write broadcast to all cells
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} ukt_wr_t;

endpackage

@@ rtl/core/ukt_req_if.sv @@
interface ukt_req_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      req_type;
	logic signed [ukt_pkg::KEY_W-1:0] key;
	logic [ukt_pkg::VAL_W-1:0]       entry_value;

	modport source (output valid, req_type, key, entry_value, input ready);
	modport sink (input valid, req_type, key, entry_value, output ready);
endinterface

@@ rtl/core/ukt_rsp_if.sv @@
interface ukt_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic [ukt_pkg::HIDX_W-1:0] hit_index;
	logic [ukt_pkg::VAL_W-1:0]  hit_value;
	logic [ukt_pkg::ECNT_W-1:0] entry_count;

	modport source (output valid, status, hit_index, hit_value, entry_count, input ready);
	modport sink (input valid, status, hit_index, hit_value, entry_count, output ready);
endinterface

@@ rtl/core/ukt_cell.sv @@
module ukt_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ukt_pkg::IDX_W-1:0]    cell_idx,
	input  logic [ukt_pkg::CNT_W-1:0]    count,
	input  ukt_pkg::ukt_wr_t             wr,
	input  ukt_pkg::ukt_tok_t            tok_in,
	output ukt_pkg::ukt_tok_t            tok_out
);

	logic [ukt_pkg::KEY_W-1:0] key_q;
	logic [ukt_pkg::VAL_W-1:0] value_q;
	logic                      tok_valid_q;
	ukt_pkg::ukt_tok_t         tok_pay_q;
	ukt_pkg::ukt_tok_t         tok_next;
	logic [ukt_pkg::CNT_W-1:0] pos;
	logic                      live;
	logic                      is_last;

	assign pos     = ukt_pkg::CNT_W'(cell_idx);
	assign live    = pos < count;
	assign is_last = (pos + ukt_pkg::CNT_W'(1)) == count;

	// entry storage, written by slot address
	always_ff @(posedge clk) begin
		if (wr.en && (wr.idx == cell_idx)) begin
			key_q   <= wr.key;
			value_q <= wr.value;
		end
	end

	// compare against the passing token, first match wins, grab the tail entry
	always_comb begin
		tok_next = tok_in;
		if (live && !tok_in.found && (key_q == tok_in.key)) begin
			tok_next.found = 1'b1;
			tok_next.slot  = cell_idx;
			tok_next.value = value_q;
		end
		if (is_last) begin
			tok_next.last_key   = key_q;
			tok_next.last_value = value_q;
		end
	end

	// hand token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_pay_q <= tok_next;
	end

	always_comb begin
		tok_out       = tok_pay_q;
		tok_out.valid = tok_valid_q;
	end

endmodule

@@ rtl/core/unordered_key_table_core.sv @@
// Unordered key/value table kept densely in slots 0 to count-1, one entry per cell of a
// row of CAPACITY cells. Insert appends at the end and goes straight to the post state; an
// unknown request type takes the same path. Search and delete send a token down the cell
// row, one cell per cycle, and their result is taken when the token leaves the last cell,
// so the row length sets how long they take. Delete moves the tail entry into the freed
// slot. One request is worked at a time; a finished result sits in the output register, and
// the next request is taken in the cycle after its result has moved there. Slot contents
// need no reset.
`include "unordered_key_table_core_macros.svh"

module unordered_key_table_core (
	input  logic      clk,
	input  logic      arst_n,
	ukt_req_if.sink   req,
	ukt_rsp_if.source rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_POST = 2'd2;

	logic [1:0]                    state_q;
	logic [ukt_pkg::CNT_W-1:0]     count_q;
	logic [1:0]                    op_q;
	logic [1:0]                    res_status_q;
	logic [ukt_pkg::IDX_W-1:0]     res_idx_q;
	logic [ukt_pkg::VAL_W-1:0]     res_value_q;
	logic                          out_valid_q;
	logic [1:0]                    out_status_q;
	logic [ukt_pkg::HIDX_W-1:0]    out_idx_q;
	logic [ukt_pkg::VAL_W-1:0]     out_value_q;
	logic [ukt_pkg::ECNT_W-1:0]    out_count_q;

	ukt_pkg::ukt_tok_t             tok [0:ukt_pkg::CAPACITY];
	ukt_pkg::ukt_tok_t             tok_end;
	ukt_pkg::ukt_wr_t              wr;
	logic                          in_xfer;
	logic                          not_full;
	logic                          out_free;
	logic                          del_hit;
	logic [ukt_pkg::IDX_W+ukt_pkg::HIDX_W-1:0]  idx_ext;
	logic [ukt_pkg::CNT_W+ukt_pkg::ECNT_W-1:0]  cnt_ext;

	assign req.ready = (state_q == S_IDLE);
	assign in_xfer   = req.valid && req.ready;
	assign not_full  = count_q < ukt_pkg::CNT_W'(ukt_pkg::CAPACITY);
	assign out_free  = !out_valid_q || rsp.ready;
	assign tok_end   = tok[ukt_pkg::CAPACITY];
	assign del_hit   = (state_q == S_SCAN) && tok_end.valid && tok_end.found
		&& (op_q == ukt_pkg::REQ_DELETE);

	// token launch into the first cell
	always_comb begin
		tok[0]            = '0;
		tok[0].valid      = in_xfer && ((req.req_type == ukt_pkg::REQ_SEARCH)
			|| (req.req_type == ukt_pkg::REQ_DELETE));
		tok[0].key        = req.key;
	end

	// slot write: append on insert, tail move on delete
	always_comb begin
		wr = '0;
		if (in_xfer && (req.req_type == ukt_pkg::REQ_INSERT) && not_full) begin
			wr.en    = 1'b1;
			wr.idx   = count_q[ukt_pkg::IDX_W-1:0];
			wr.key   = req.key;
			wr.value = req.entry_value;
		end else if (del_hit) begin
			wr.en    = 1'b1;
			wr.idx   = tok_end.slot;
			wr.key   = tok_end.last_key;
			wr.value = tok_end.last_value;
		end
	end

	// cell row
	for (genvar i = 0; i < ukt_pkg::CAPACITY; i++) begin : g_cell
		ukt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (ukt_pkg::IDX_W'(i)),
			.count    (count_q),
			.wr       (wr),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1])
		);
	end

	// sequencer and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if ((req.req_type == ukt_pkg::REQ_SEARCH)
							|| (req.req_type == ukt_pkg::REQ_DELETE)) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_POST;
						end
						if ((req.req_type == ukt_pkg::REQ_INSERT) && not_full) begin
							count_q <= count_q + ukt_pkg::CNT_W'(1);
						end
					end
				end
				S_SCAN: begin
					if (tok_end.valid) begin
						state_q <= S_POST;
						if (del_hit) begin
							count_q <= count_q - ukt_pkg::CNT_W'(1);
						end
					end
				end
				S_POST: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q         <= req.req_type;
			res_status_q <= ukt_pkg::ST_MISS;
			res_idx_q    <= '0;
			res_value_q  <= '0;
			if (req.req_type == ukt_pkg::REQ_INSERT) begin
				if (not_full) begin
					res_status_q <= ukt_pkg::ST_OK;
					res_idx_q    <= count_q[ukt_pkg::IDX_W-1:0];
				end else begin
					res_status_q <= ukt_pkg::ST_FULL;
				end
			end
		end else if ((state_q == S_SCAN) && tok_end.valid && tok_end.found) begin
			res_status_q <= ukt_pkg::ST_OK;
			res_idx_q    <= tok_end.slot;
			if (op_q == ukt_pkg::REQ_SEARCH) begin
				res_value_q <= tok_end.value;
			end
		end
	end

	// output register
	assign idx_ext = {{ukt_pkg::HIDX_W{1'b0}}, res_idx_q};
	assign cnt_ext = {{ukt_pkg::ECNT_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_POST) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_POST) && out_free) begin
			out_status_q <= res_status_q;
			out_idx_q    <= idx_ext[ukt_pkg::HIDX_W-1:0];
			out_value_q  <= res_value_q;
			out_count_q  <= cnt_ext[ukt_pkg::ECNT_W-1:0];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.hit_index   = out_idx_q;
	assign rsp.hit_value   = out_value_q;
	assign rsp.entry_count = out_count_q;

	// checks
	`UKT_ASSERT_IMP(a_count_cap, clk, arst_n, 1'b1,
		count_q <= ukt_pkg::CNT_W'(ukt_pkg::CAPACITY))
	`UKT_ASSERT_IMP(a_no_token_idle, clk, arst_n, state_q == S_IDLE, !tok_end.valid)
	`UKT_ASSERT_NXT(a_insert_grows, clk, arst_n,
		in_xfer && (req.req_type == ukt_pkg::REQ_INSERT) && not_full,
		count_q == $past(count_q) + ukt_pkg::CNT_W'(1))
	`UKT_ASSERT_NXT(a_delete_shrinks, clk, arst_n, del_hit,
		count_q == $past(count_q) - ukt_pkg::CNT_W'(1))

endmodule
